>>> rtl/core/cpmd_pkg.sv
// Shared types and constants of the clamped PID motor drive.
package cpmd_pkg;

  // Field widths.
  localparam int SAMPLE_W = 8;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 15;
  localparam int SUM_W    = 16;
  localparam int DRIVE_W  = 11;
  localparam int DIR_W    = 2;
  localparam int MAG_W    = 10;
  localparam int OFFS_W   = 7;

  // The serial multiplier takes a signed operand and an unsigned gain.
  localparam int OPND_W = 21;
  localparam int PROD_W = OPND_W + 1 + GAIN_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIM  = 2'd3;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET    = 15'd30000;

  // Scaling and saturation constants.
  localparam int SUM_SHIFT    = 8;
  localparam int INTEG_SHIFT  = 4;
  localparam int DERIV_SHIFT  = 5;
  localparam int DRIVE_SHIFT  = 10;
  localparam int DERIV_CLAMP  = 120;
  localparam int DRIVE_LIMIT  = 1000;
  localparam int OFFSET_LIMIT = 55;

  // Drive direction codes.
  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_t;

  // Status of the serial multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_status_t;

endpackage

>>> rtl/core/cpmd_if.sv
// Valid/ready channel interfaces for the error sample and drive result words.
interface cpmd_in_if import cpmd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] error_sample;

  modport source (output valid, output error_sample, input ready);
  modport sink   (input valid, input error_sample, output ready);
endinterface

interface cpmd_out_if import cpmd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_value;
  logic [DIR_W-1:0]          drive_direction;
  logic [MAG_W-1:0]          duty_magnitude;
  logic signed [OFFS_W-1:0]  angle_offset;

  modport source (output valid, output drive_value, output drive_direction,
                  output duty_magnitude, output angle_offset, input ready);
  modport sink   (input valid, input drive_value, input drive_direction,
                  input duty_magnitude, input angle_offset, output ready);
endinterface

>>> rtl/core/clamped_pid_motor_drive.sv
// Top level of the clamped PID motor drive controller.
//
// The sample channel takes one signed error word per control step; the
// result channel returns one word with the saturated drive, its direction,
// its magnitude and the updated offset count. Write the gains and integral
// limit through the plain write port only while idle; it is not enforced.
//
// One shared bit-serial multiplier forms the integral, derivative and drive
// products in turn, sixteen gain bits each. An accepted word passes through
// the integral, derivative, sum, drive and finish states to the result
// register; a new word is accepted only once the sequencer is back in idle,
// so no word is taken while the one before is still being worked on.
//
// Reset clears the error sum, the sample history, the offset count and the
// gains, and sets the integral limit to 30000. If the receiver stalls, the
// finished result waits in the output register; the next word may already
// be accepted and worked on, and its result waits until the register frees.
module clamped_pid_motor_drive import cpmd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  cpmd_in_if.sink               sample,
  cpmd_out_if.source            result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DIFF_W  = SAMPLE_W + 1;
  localparam int DERIV_W = 8;
  localparam int DPROD_W = SAMPLE_W + GAIN_W - DERIV_SHIFT;
  localparam int DRV_F_W = PROD_W - DRIVE_SHIFT;

  localparam logic signed [DIFF_W-1:0]  DIFF_HI  = DIFF_W'(DERIV_CLAMP);
  localparam logic signed [DIFF_W-1:0]  DIFF_LO  = -DIFF_HI;
  localparam logic signed [DPROD_W-1:0] DPROD_HI = DPROD_W'(DERIV_CLAMP);
  localparam logic signed [DPROD_W-1:0] DPROD_LO = -DPROD_HI;
  localparam logic signed [DRV_F_W-1:0] DRV_HI   = DRV_F_W'(DRIVE_LIMIT);
  localparam logic signed [DRV_F_W-1:0] DRV_LO   = -DRV_HI;
  localparam logic signed [OFFS_W-1:0]  OFFS_HI  = OFFS_W'(OFFSET_LIMIT);
  localparam logic signed [OFFS_W-1:0]  OFFS_LO  = -OFFS_HI;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_INTEG  = 6'b000010,
    ST_DERIV  = 6'b000100,
    ST_SUM    = 6'b001000,
    ST_DRIVE  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  integ_gain;
  logic [GAIN_W-1:0]  deriv_gain;
  logic [LIMIT_W-1:0] integ_limit;

  // Controller state.
  logic signed [SUM_W-1:0]    error_sum;
  logic signed [SAMPLE_W-1:0] hist0;
  logic signed [SAMPLE_W-1:0] hist1;
  logic signed [SAMPLE_W-1:0] hist2;
  logic signed [OFFS_W-1:0]   offset_count;

  // Per-word working registers.
  logic signed [SAMPLE_W-1:0] err;
  logic signed [DERIV_W-1:0]  diff;
  logic signed [OPND_W-1:0]   integ;
  logic signed [DERIV_W-1:0]  deriv;
  logic signed [DRIVE_W-1:0]  drive;

  // Multiplier hookup.
  logic                     mul_start;
  logic signed [OPND_W-1:0] mul_opnd;
  logic [GAIN_W-1:0]        mul_gain;
  mul_status_t              mul_stat;
  logic signed [PROD_W-1:0] mul_prod;

  // Output register.
  logic                      out_valid;
  logic signed [DRIVE_W-1:0] out_drive;
  logic [DIR_W-1:0]          out_dir;
  logic [MAG_W-1:0]          out_mag;
  logic signed [OFFS_W-1:0]  out_offs;

  logic accept;
  logic slot_free;

  logic signed [SUM_W:0]      sum_wide;
  logic signed [SUM_W:0]      lim_hi;
  logic signed [SUM_W:0]      lim_lo;
  logic signed [SUM_W-1:0]    sum_next;
  logic signed [DIFF_W-1:0]   diff_wide;
  logic signed [DERIV_W-1:0]  diff_next;
  logic signed [DPROD_W-1:0]  dprod;
  logic signed [DERIV_W-1:0]  deriv_next;
  logic signed [DRV_F_W-1:0]  drv_full;
  logic signed [DRIVE_W-1:0]  drive_next;
  logic signed [OPND_W-1:0]   total;
  logic [DIR_W-1:0]           dir_next;
  logic [MAG_W-1:0]           mag_next;
  logic signed [OFFS_W-1:0]   offset_next;

  assign accept    = sample.valid && sample.ready;
  assign slot_free = !out_valid || result.ready;
  assign sample.ready = (state == ST_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      integ_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PROP_GAIN:  prop_gain   <= cfg_data;
        REG_INTEG_GAIN: integ_gain  <= cfg_data;
        REG_DERIV_GAIN: deriv_gain  <= cfg_data;
        REG_INTEG_LIM:  integ_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Error sum with the upper clamp tested before the lower one.
  always_comb begin
    sum_wide = {error_sum[SUM_W-1], error_sum}
               + (SUM_W + 1)'(sample.error_sample);
    lim_hi   = {2'b00, integ_limit};
    lim_lo   = (SUM_W + 1)'(1) - lim_hi;
    if (sum_wide > lim_hi) begin
      sum_next = lim_hi[SUM_W-1:0];
    end else if (sum_wide < lim_lo) begin
      sum_next = lim_lo[SUM_W-1:0];
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end
  end

  // Difference against the sample three steps back, clamped.
  always_comb begin
    diff_wide = DIFF_W'(sample.error_sample) - DIFF_W'(hist2);
    if (diff_wide > DIFF_HI) begin
      diff_next = DERIV_W'(DIFF_HI);
    end else if (diff_wide < DIFF_LO) begin
      diff_next = DERIV_W'(DIFF_LO);
    end else begin
      diff_next = diff_wide[DERIV_W-1:0];
    end
  end

  // Scaled derivative product, clamped.
  always_comb begin
    dprod = mul_prod[DERIV_SHIFT+DPROD_W-1:DERIV_SHIFT];
    if (dprod > DPROD_HI) begin
      deriv_next = DERIV_W'(DPROD_HI);
    end else if (dprod < DPROD_LO) begin
      deriv_next = DERIV_W'(DPROD_LO);
    end else begin
      deriv_next = dprod[DERIV_W-1:0];
    end
  end

  // Scaled drive product, saturated.
  always_comb begin
    drv_full = mul_prod[PROD_W-1:DRIVE_SHIFT];
    if (drv_full > DRV_HI) begin
      drive_next = DRIVE_W'(DRV_HI);
    end else if (drv_full < DRV_LO) begin
      drive_next = DRIVE_W'(DRV_LO);
    end else begin
      drive_next = drv_full[DRIVE_W-1:0];
    end
  end

  // Sum of the three terms ahead of the drive multiplication.
  assign total = OPND_W'(err) + integ + OPND_W'(deriv);

  // Direction, magnitude and offset count from the finished drive.
  always_comb begin
    offset_next = offset_count;
    if (drive == '0) begin
      dir_next = DIR_STOP;
      mag_next = '0;
    end else if (drive > DRIVE_W'(0)) begin
      dir_next = DIR_FWD;
      mag_next = drive[MAG_W-1:0];
      if (offset_count < OFFS_HI) begin
        offset_next = offset_count + OFFS_W'(1);
      end
    end else begin
      dir_next = DIR_BACK;
      mag_next = MAG_W'(-drive);
      if (offset_count > OFFS_LO) begin
        offset_next = offset_count - OFFS_W'(1);
      end
    end
  end

  // Sequencer and controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mul_start    <= 1'b0;
      out_valid    <= 1'b0;
      error_sum    <= '0;
      hist0        <= '0;
      hist1        <= '0;
      hist2        <= '0;
      offset_count <= '0;
    end else begin
      mul_start <= 1'b0;
      if (state == ST_FINISH && slot_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            error_sum <= sum_next;
            hist0     <= sample.error_sample;
            hist1     <= hist0;
            hist2     <= hist1;
            mul_start <= 1'b1;
            state     <= ST_INTEG;
          end
        end
        ST_INTEG: begin
          if (mul_stat.done) begin
            mul_start <= 1'b1;
            state     <= ST_DERIV;
          end
        end
        ST_DERIV: begin
          if (mul_stat.done) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          mul_start <= 1'b1;
          state     <= ST_DRIVE;
        end
        ST_DRIVE: begin
          if (mul_stat.done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            offset_count <= offset_next;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Working registers and multiplier operands.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          err      <= sample.error_sample;
          diff     <= diff_next;
          mul_opnd <= OPND_W'($signed(sum_next[SUM_W-1:SUM_SHIFT]));
          mul_gain <= integ_gain;
        end
      end
      ST_INTEG: begin
        if (mul_stat.done) begin
          integ    <= mul_prod[INTEG_SHIFT+OPND_W-1:INTEG_SHIFT];
          mul_opnd <= OPND_W'(diff);
          mul_gain <= deriv_gain;
        end
      end
      ST_DERIV: begin
        if (mul_stat.done) begin
          deriv <= deriv_next;
        end
      end
      ST_SUM: begin
        mul_opnd <= total;
        mul_gain <= prop_gain;
      end
      ST_DRIVE: begin
        if (mul_stat.done) begin
          drive <= drive_next;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_drive <= drive;
          out_dir   <= dir_next;
          out_mag   <= mag_next;
          out_offs  <= offset_next;
        end
      end
      default: ;
    endcase
  end

  cpmd_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .opnd    (mul_opnd),
    .gain    (mul_gain),
    .status  (mul_stat),
    .product (mul_prod)
  );

  assign result.valid           = out_valid;
  assign result.drive_value     = out_drive;
  assign result.drive_direction = out_dir;
  assign result.duty_magnitude  = out_mag;
  assign result.angle_offset    = out_offs;

endmodule

>>> rtl/core/cpmd_serial_mul.sv
// Bit-serial signed-by-unsigned multiplier, one gain bit per cycle.
module cpmd_serial_mul import cpmd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [OPND_W-1:0] opnd,
  input  logic [GAIN_W-1:0]        gain,
  output mul_status_t              status,
  output logic signed [PROD_W-1:0] product
);

  localparam int CNT_W = $clog2(GAIN_W);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(GAIN_W - 1);

  logic signed [OPND_W-1:0] opnd_q;
  logic signed [OPND_W:0]   hi;
  logic [GAIN_W-1:0]        lo;
  logic signed [OPND_W:0]   part;
  logic [CNT_W-1:0]         cnt;
  logic                     busy;
  logic                     done;

  // Add the operand when the current gain bit is set.
  assign part = hi + (lo[0] ? {opnd_q[OPND_W-1], opnd_q} : (OPND_W + 1)'(0));

  // Sequencing of the bit steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_BIT) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial product shifts right; the gain bits give way to product bits.
  always_ff @(posedge clk) begin
    if (start) begin
      opnd_q <= opnd;
      hi     <= '0;
      lo     <= gain;
    end else if (busy) begin
      hi <= {part[OPND_W], part[OPND_W:1]};
      lo <= {part[0], lo[GAIN_W-1:1]};
    end
  end

  assign product = {hi, lo};
  assign status  = '{busy: busy, done: done};

endmodule

>>> tb/cpmd_drive_checker.sv
`timescale 1ns / 100ps
// Checker that predicts each drive result word of the PID motor drive and compares it.
module cpmd_drive_checker import cpmd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  cpmd_in_if                    sample_ch,
  cpmd_out_if                   result_ch,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    pending_words
);

  // One predicted result word.
  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    dir_t                      dir;
    logic [MAG_W-1:0]          mag;
    logic signed [OFFS_W-1:0]  offs;
  } drive_word_t;

  drive_word_t expected_words[$];

  // Shadow copy of the gains, the limit and the controller state.
  logic [GAIN_W-1:0]          kp_q;
  logic [GAIN_W-1:0]          ki_q;
  logic [GAIN_W-1:0]          kd_q;
  logic [LIMIT_W-1:0]         lim_q;
  logic signed [SUM_W-1:0]    err_sum;
  logic signed [SAMPLE_W-1:0] err_hist [3];
  logic signed [OFFS_W-1:0]   offs_q;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Advances the shadow state by one error sample and returns the drive word.
  function automatic drive_word_t step_controller(input logic signed [SAMPLE_W-1:0] err);
    drive_word_t w;
    longint e;
    longint acc;
    longint lo;
    longint integ;
    longint deriv;
    longint drv;
    e  = longint'(err);
    lo = 1 - longint'(lim_q);

    // The upper clamp wins; the lower one applies only otherwise.
    acc = longint'(err_sum) + e;
    if (acc > longint'(lim_q)) begin
      acc = longint'(lim_q);
    end else if (acc < lo) begin
      acc = lo;
    end
    err_sum = acc[SUM_W-1:0];

    integ = ((acc >>> SUM_SHIFT) * longint'(ki_q)) >>> INTEG_SHIFT;

    deriv = e - longint'(err_hist[2]);
    if (deriv > DERIV_CLAMP) deriv = DERIV_CLAMP;
    if (deriv < -DERIV_CLAMP) deriv = -DERIV_CLAMP;
    deriv = (deriv * longint'(kd_q)) >>> DERIV_SHIFT;
    if (deriv > DERIV_CLAMP) deriv = DERIV_CLAMP;
    if (deriv < -DERIV_CLAMP) deriv = -DERIV_CLAMP;

    drv = ((e + integ + deriv) * longint'(kp_q)) >>> DRIVE_SHIFT;
    if (drv > DRIVE_LIMIT) drv = DRIVE_LIMIT;
    if (drv < -DRIVE_LIMIT) drv = -DRIVE_LIMIT;

    // Direction, magnitude and the saturating offset count.
    if (drv == 0) begin
      w.dir = DIR_STOP;
      w.mag = '0;
    end else if (drv > 0) begin
      w.dir = DIR_FWD;
      w.mag = drv[MAG_W-1:0];
      if (offs_q < OFFSET_LIMIT) offs_q = offs_q + 7'sd1;
    end else begin
      w.dir = DIR_BACK;
      w.mag = MAG_W'(-drv);
      if (offs_q > -OFFSET_LIMIT) offs_q = offs_q - 7'sd1;
    end
    w.drive = drv[DRIVE_W-1:0];
    w.offs  = offs_q;

    err_hist[2] = err_hist[1];
    err_hist[1] = err_hist[0];
    err_hist[0] = err;
    return w;
  endfunction

  // Watch the configuration port and both channels at every rising edge.
  always @(posedge clk) begin : monitor
    drive_word_t want;
    if (rst) begin
      kp_q     = '0;
      ki_q     = '0;
      kd_q     = '0;
      lim_q    = LIMIT_RESET;
      err_sum  = '0;
      err_hist = '{default: '0};
      offs_q   = '0;
      expected_words.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_PROP_GAIN:  kp_q  = cfg_data;
          REG_INTEG_GAIN: ki_q  = cfg_data;
          REG_DERIV_GAIN: kd_q  = cfg_data;
          REG_INTEG_LIM:  lim_q = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (sample_ch.valid && sample_ch.ready) begin
        expected_words.push_back(step_controller(sample_ch.error_sample));
      end
      if (result_ch.valid && result_ch.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("result word with no expected word waiting");
        end else begin
          want = expected_words.pop_front();
          if (result_ch.drive_value !== want.drive)
            report_mismatch($sformatf("drive_value got %0d want %0d",
                                      result_ch.drive_value, want.drive));
          if (result_ch.drive_direction !== want.dir)
            report_mismatch($sformatf("drive_direction got %0d want %0d",
                                      result_ch.drive_direction, want.dir));
          if (result_ch.duty_magnitude !== want.mag)
            report_mismatch($sformatf("duty_magnitude got %0d want %0d",
                                      result_ch.duty_magnitude, want.mag));
          if (result_ch.angle_offset !== want.offs)
            report_mismatch($sformatf("angle_offset got %0d want %0d",
                                      result_ch.angle_offset, want.offs));
        end
      end
    end
    pending_words = expected_words.size();
  end

endmodule

>>> tb/tb_clamped_pid_motor_drive.sv
`timescale 1ns / 100ps
// Top of the PID motor drive testbench: clock, reset, stimulus, back pressure and verdict.
module tb_clamped_pid_motor_drive;
  import cpmd_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASES       = 8;
  localparam int LONG_HOLD    = 600;
  localparam int TAIL_CYCLES  = 120;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatch_count;
  int                    pending_words;
  int                    idle_pct;
  int                    stall_pct;
  logic                  long_hold_req;
  int                    cycle_count;

  cpmd_in_if  sample_ch ();
  cpmd_out_if result_ch ();

  clamped_pid_motor_drive i_dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cpmd_drive_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .sample_ch      (sample_ch),
    .result_ch      (result_ch),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offers one error word, with a random gap first when the sender idles.
  task automatic send_word(input logic signed [SAMPLE_W-1:0] e);
    int gap;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 70) : $urandom_range(1, 3);
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.error_sample <= e;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // Stops offering and waits until every expected word has come back.
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all four registers while the block is idle.
  task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                           input logic [GAIN_W-1:0] kd, input logic [LIMIT_W-1:0] lim);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= REG_PROP_GAIN;
    cfg_data  <= kp;
    @(posedge clk);
    cfg_index <= REG_INTEG_GAIN;
    cfg_data  <= ki;
    @(posedge clk);
    cfg_index <= REG_DERIV_GAIN;
    cfg_data  <= kd;
    @(posedge clk);
    cfg_index <= REG_INTEG_LIM;
    cfg_data  <= CFG_DATA_W'(lim);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Directed words, then random phases with varying gains and idling.
  initial begin : stimulus
    int unit_seq [12] = '{0, 127, 127, 127, -128, -128, -128, 1, -1, 0, 127, -128};
    int edge_seq [5]  = '{127, -128, 0, 1, -1};
    int per_phase;
    int run_left;
    bit run_pos;
    int sel;
    logic signed [SAMPLE_W-1:0] e;

    sample_ch.valid        <= 1'b0;
    sample_ch.error_sample <= '0;
    cfg_write              <= 1'b0;
    cfg_index              <= REG_PROP_GAIN;
    cfg_data               <= '0;
    rst                    <= 1'b1;
    idle_pct      = 0;
    stall_pct     = 0;
    long_hold_req = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Unity-like gains: full-scale steps and a derivative over three samples.
    set_gains(16'd1024, 16'd16, 16'd32, 15'd30000);
    foreach (unit_seq[i]) send_word(SAMPLE_W'(unit_seq[i]));

    // Zero integral limit: positive sums go to zero, all others to one.
    set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'd0);
    foreach (edge_seq[i]) send_word(SAMPLE_W'(edge_seq[i]));

    // Zero proportional gain gives zero drive and holds the offset count.
    set_gains(16'd0, 16'hFFFF, 16'hFFFF, 15'h7FFF);
    send_word(8'sd127);
    send_word(-8'sd128);
    send_word(8'sd0);

    per_phase = RANDOM_ITEMS / PHASES;
    run_left  = 0;
    run_pos   = 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF);
        1: set_gains(16'd1, 16'd0, 16'd0, 15'd1);
        2: set_gains(16'($urandom_range(0, 4095)), 16'($urandom), 16'($urandom), 15'd0);
        3: set_gains(16'd1024, 16'hFFFF, 16'd0, 15'h7FFF);
        default: set_gains(16'($urandom_range(0, 4095)), 16'($urandom), 16'($urandom),
                           15'($urandom_range(1, 32767)));
      endcase

      // Idling mode: none, sender only, receiver only, both.
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase

      for (int n = 0; n < per_phase; n++) begin
        // Long receiver hold-off while the sender keeps offering.
        if (p == 0 && n == 30) long_hold_req = 1'b1;

        // Runs of one sign drive the integrator and the offset count to saturation.
        if (run_left == 0) begin
          run_left = $urandom_range(60, 150);
          run_pos  = $urandom_range(0, 1);
        end
        run_left--;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
          e = SAMPLE_W'($urandom);
        end else if (sel < 7) begin
          case ($urandom_range(0, 4))
            0: e = 8'sd127;
            1: e = -8'sd128;
            2: e = 8'sd1;
            3: e = -8'sd1;
            default: e = 8'sd0;
          endcase
        end else begin
          e = {~run_pos, 7'($urandom)};
        end
        send_word(e);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
